// ===== sv/cht_pkg.sv =====
// shared types and constants for the chained hash table
// no dependencies
`default_nettype none
package cht_pkg;
	localparam int MAX_BUCKETS_DEF  = 64;
	localparam int NODE_POOL_DEF    = 256;
	localparam int PAYLOAD_BITS_DEF = 32;
	localparam int CFG_BITS         = 7;
	localparam logic [CFG_BITS-1:0] BUCKET_COUNT_RST = 7'd51;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_SEARCH = 2'd2,
		MODE_REMOVE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_DUP  = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic signed [31:0] key_in;
		logic [31:0] payload_in;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] payload_out;
	} out_item_t;

	typedef enum logic [3:0] {
		BK_IDLE, BK_CLEAR, BK_HEAD, BK_RD, BK_CMP, BK_LINK, BK_FIX, BK_OUT, BK_INIT
	} bk_state_t;
endpackage
`default_nettype wire

// ===== sv/cht_front.sv =====
// front end: accepts items, reduces key to bucket index, queues them
// depends on cht_pkg
`default_nettype none
module cht_front #(
	parameter int MAX_BUCKETS = cht_pkg::MAX_BUCKETS_DEF,
	parameter int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [cht_pkg::CFG_BITS-1:0] bucket_count,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire cht_pkg::in_item_t          in_item,
	output logic                            q_valid,
	input  wire logic                       q_pop,
	output cht_pkg::in_item_t               q_item,
	output logic [BW-1:0]                   q_bucket
);
	localparam int MW = $clog2(MAX_BUCKETS + 1) + 1;
	// restoring remainder over the 32-bit key magnitude, 4 bits per cycle
	logic busy_q;
	logic [2:0] cnt_q;
	logic [31:0] mag_q;
	logic [MW-1:0] rem_q, m_q;
	logic neg_q;
	cht_pkg::in_item_t item_q;
	logic [1:0] fill_q;
	cht_pkg::in_item_t qi_q [2];
	logic [BW-1:0] qb_q [2];
	logic wr_q, rd_q;
	logic [MW-1:0] r_nx, m_eff, fin;
	logic done;

	always_comb begin
		if (bucket_count == '0) m_eff = MW'(1);
		else if (32'(bucket_count) > 32'(MAX_BUCKETS)) m_eff = MW'(MAX_BUCKETS);
		else m_eff = MW'(bucket_count);
	end

	always_comb begin
		logic [MW:0] t;
		t = '0;
		r_nx = rem_q;
		for (int i = 0; i < 4; i++) begin
			t = {r_nx, mag_q[31 - i]};
			if (t >= {1'b0, m_q}) t = t - {1'b0, m_q};
			r_nx = t[MW-1:0];
		end
	end

	assign done = busy_q && cnt_q == 3'd7;
	always_comb begin
		if (neg_q && r_nx != '0) fin = m_q - r_nx;
		else fin = r_nx;
	end

	assign in_stall = busy_q || (fill_q == 2'd2);
	assign q_valid = fill_q != 2'd0;
	assign q_item = qi_q[rd_q];
	assign q_bucket = qb_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			fill_q <= '0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (done) busy_q <= 1'b0;
			end
			if (done) wr_q <= !wr_q;
			if (q_pop && q_valid) rd_q <= !rd_q;
			fill_q <= fill_q + {1'b0, done} - {1'b0, q_pop && q_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_q <= in_item;
			neg_q <= in_item.key_in[31];
			mag_q <= in_item.key_in[31] ? (~in_item.key_in + 32'd1) : in_item.key_in;
			rem_q <= '0;
			m_q <= m_eff;
		end else if (busy_q) begin
			rem_q <= r_nx;
			mag_q <= {mag_q[27:0], 4'd0};
		end
		if (done) begin
			qi_q[wr_q] <= item_q;
			qb_q[wr_q] <= BW'(fin);
		end
	end

`ifndef SYNTH
	a_fill: assert property (@(posedge clk) disable iff (!arst_n) fill_q <= 2'd2)
		else $error("queue overflow");
	a_nodone_full: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> fill_q != 2'd2 || q_pop) else $error("push into full queue");
	a_rem: assert property (@(posedge clk) disable iff (!arst_n) done |-> fin < m_q)
		else $error("bucket out of range");
`endif
endmodule
`default_nettype wire

// ===== sv/cht_back.sv =====
// back end: walks bucket chains in node memory and executes operations
// depends on cht_pkg
`default_nettype none
module cht_back #(
	parameter int MAX_BUCKETS  = cht_pkg::MAX_BUCKETS_DEF,
	parameter int NODE_POOL    = cht_pkg::NODE_POOL_DEF,
	parameter int PAYLOAD_BITS = cht_pkg::PAYLOAD_BITS_DEF,
	parameter int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	output logic                   q_pop,
	input  wire cht_pkg::in_item_t q_item,
	input  wire logic [BW-1:0]     q_bucket,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output cht_pkg::out_item_t     out_item
);
	localparam int LW = $clog2(NODE_POOL + 1);
	localparam int IW = $clog2(NODE_POOL);
	localparam logic [LW-1:0] EMPTY = LW'(NODE_POOL);

	logic [LW-1:0] heads_q [MAX_BUCKETS];
	logic [31:0] nkey_mem [NODE_POOL];
	logic [PAYLOAD_BITS-1:0] npay_mem [NODE_POOL];
	logic [LW-1:0] nlink_mem [NODE_POOL];

	cht_pkg::bk_state_t st_q, st_d;
	cht_pkg::in_item_t it_q;
	cht_pkg::out_item_t res_q;
	logic [BW-1:0] b_q;
	logic [LW-1:0] cur_q, prev_q, free_q, steps_q, head_q;
	logic [31:0] rkey_q;
	logic [PAYLOAD_BITS-1:0] rpay_q;
	logic [LW-1:0] rlink_q;
	logic [BW:0] clr_q;
	logic found;
	logic ov_q;
	// hit flag: set when the walk ended on a matching node
	logic hit_q;
	logic ins_new;

	assign found = rkey_q == it_q.key_in;
	assign q_pop = st_q == cht_pkg::BK_IDLE && q_valid;
	assign out_valid = ov_q;
	assign ins_new = it_q.mode == cht_pkg::MODE_INSERT && !hit_q && free_q != EMPTY;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			cht_pkg::BK_INIT: if (32'(clr_q) == MAX_BUCKETS - 1) st_d = cht_pkg::BK_IDLE;
			cht_pkg::BK_IDLE: if (q_valid)
				st_d = (q_item.mode == cht_pkg::MODE_CLEAR) ? cht_pkg::BK_CLEAR
					: cht_pkg::BK_HEAD;
			cht_pkg::BK_CLEAR: if (32'(clr_q) == MAX_BUCKETS - 1) st_d = cht_pkg::BK_OUT;
			cht_pkg::BK_HEAD: st_d = cht_pkg::BK_RD;
			cht_pkg::BK_RD: st_d = (cur_q == EMPTY || steps_q == EMPTY)
				? cht_pkg::BK_LINK : cht_pkg::BK_CMP;
			cht_pkg::BK_CMP: st_d = found ? cht_pkg::BK_LINK : cht_pkg::BK_RD;
			cht_pkg::BK_LINK: st_d = cht_pkg::BK_FIX;
			cht_pkg::BK_FIX: st_d = cht_pkg::BK_OUT;
			cht_pkg::BK_OUT: if (!ov_q || !out_stall) st_d = cht_pkg::BK_IDLE;
			default: st_d = cht_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= cht_pkg::BK_INIT;
			free_q <= '0;
			ov_q <= 1'b0;
			clr_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == cht_pkg::BK_OUT && (!ov_q || !out_stall)) ov_q <= 1'b1;
			else if (ov_q && !out_stall) ov_q <= 1'b0;
			unique case (st_q)
				cht_pkg::BK_IDLE: clr_q <= '0;
				cht_pkg::BK_INIT: clr_q <= clr_q + 1'b1;
				cht_pkg::BK_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					free_q <= '0;
				end
				cht_pkg::BK_FIX: if (ins_new) free_q <= free_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			cht_pkg::BK_INIT: heads_q[clr_q[BW-1:0]] <= EMPTY;
			cht_pkg::BK_IDLE: if (q_valid) begin
				it_q <= q_item;
				b_q <= q_bucket;
				hit_q <= 1'b0;
			end
			cht_pkg::BK_HEAD: begin
				cur_q <= heads_q[b_q];
				head_q <= heads_q[b_q];
				prev_q <= EMPTY;
				steps_q <= '0;
			end
			cht_pkg::BK_RD: if (cur_q != EMPTY) begin
				rkey_q <= nkey_mem[cur_q[IW-1:0]];
				rpay_q <= npay_mem[cur_q[IW-1:0]];
				rlink_q <= nlink_mem[cur_q[IW-1:0]];
			end
			cht_pkg::BK_CMP: if (found) hit_q <= 1'b1;
				else begin
					prev_q <= cur_q;
					cur_q <= rlink_q;
					steps_q <= steps_q + 1'b1;
				end
			cht_pkg::BK_LINK: begin
				if (ins_new) begin
					nkey_mem[free_q[IW-1:0]] <= it_q.key_in;
					npay_mem[free_q[IW-1:0]] <= PAYLOAD_BITS'(it_q.payload_in);
					nlink_mem[free_q[IW-1:0]] <= head_q;
				end else if (it_q.mode == cht_pkg::MODE_REMOVE && hit_q && prev_q != EMPTY)
					nlink_mem[prev_q[IW-1:0]] <= rlink_q;
			end
			cht_pkg::BK_FIX: begin
				if (ins_new)
					heads_q[b_q] <= free_q;
				else if (it_q.mode == cht_pkg::MODE_REMOVE && hit_q && prev_q == EMPTY)
					heads_q[b_q] <= rlink_q;
				res_q.payload_out <= '0;
				unique case (it_q.mode)
					cht_pkg::MODE_INSERT: res_q.status <= hit_q ? cht_pkg::ST_DUP
						: (free_q == EMPTY ? cht_pkg::ST_FULL : cht_pkg::ST_OK);
					cht_pkg::MODE_SEARCH: begin
						res_q.status <= hit_q ? cht_pkg::ST_OK : cht_pkg::ST_MISS;
						if (hit_q) res_q.payload_out <= 32'(rpay_q);
					end
					cht_pkg::MODE_REMOVE:
						res_q.status <= hit_q ? cht_pkg::ST_OK : cht_pkg::ST_MISS;
					default: res_q.status <= cht_pkg::ST_OK;
				endcase
			end
			cht_pkg::BK_CLEAR: begin
				heads_q[clr_q[BW-1:0]] <= EMPTY;
				res_q.status <= cht_pkg::ST_OK;
				res_q.payload_out <= '0;
			end
			cht_pkg::BK_OUT: if (!ov_q || !out_stall) out_item <= res_q;
			default: ;
		endcase
	end

`ifndef SYNTH
	a_free: assert property (@(posedge clk) disable iff (!arst_n) free_q <= EMPTY)
		else $error("pool counter past end");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> st_q != cht_pkg::BK_IDLE) else $error("pop without start");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && out_stall |=> ov_q && $stable(out_item)) else $error("result dropped");
`endif
endmodule
`default_nettype wire

// ===== sv/chained_hash_table_top.sv =====
// hash table with separate chaining: bucket remainder front end, chain walk back end
// clear resets every bucket head in the back end and empties the node pool
// throughput: one item at a time in the back end, set by the serial chain walk
// through node memory; the front end reduces the next key while the back end works
// reset: asynchronous, bucket_count to 51, pool empty; an init pass (BK_INIT) then clears every bucket head
`default_nettype none
module chained_hash_table_top #(
	parameter int MAX_BUCKETS  = cht_pkg::MAX_BUCKETS_DEF,
	parameter int NODE_POOL    = cht_pkg::NODE_POOL_DEF,
	parameter int PAYLOAD_BITS = cht_pkg::PAYLOAD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [cht_pkg::CFG_BITS-1:0] cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire cht_pkg::in_item_t            in_item,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output cht_pkg::out_item_t                out_item
);
	localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	logic [cht_pkg::CFG_BITS-1:0] bucket_count_q;
	logic q_valid, q_pop;
	cht_pkg::in_item_t q_item;
	logic [BW-1:0] q_bucket;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bucket_count_q <= cht_pkg::BUCKET_COUNT_RST;
		else if (cfg_we) bucket_count_q <= cfg_wdata;
	end

	cht_front #(.MAX_BUCKETS(MAX_BUCKETS), .BW(BW)) u_front (
		.clk, .arst_n, .bucket_count(bucket_count_q), .in_valid, .in_stall, .in_item,
		.q_valid, .q_pop, .q_item, .q_bucket);

	cht_back #(.MAX_BUCKETS(MAX_BUCKETS), .NODE_POOL(NODE_POOL),
		.PAYLOAD_BITS(PAYLOAD_BITS), .BW(BW)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_item, .q_bucket,
		.out_valid, .out_stall, .out_item);
endmodule
`default_nettype wire
